// File: design/i2crts_pkg.sv
// Package for the I2C register transfer sequencer: codes, state and result types.
// No dependencies; used by i2crts_step and i2c_register_transfer_sequencer_core.
package i2crts_pkg;

  // Command codes on the func field
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EVENT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Status reported with every result
  typedef enum logic [2:0] {
    STS_NONE     = 3'd0,
    STS_STARTED  = 3'd1,
    STS_BUSY     = 3'd2,
    STS_ZERO_LEN = 3'd3,
    STS_SUCCESS  = 3'd4,
    STS_NACK     = 3'd5,
    STS_BUS_ERR  = 3'd6,
    STS_RSVD     = 3'd7
  } status_t;

  // Transfer state
  typedef enum logic [2:0] {
    XS_IDLE    = 3'd0,
    XS_BUSY    = 3'd1,
    XS_SUCCESS = 3'd2,
    XS_NACK    = 3'd3,
    XS_BUS_ERR = 3'd4
  } xfer_state_t;

  // Phase within a transfer
  typedef enum logic [1:0] {
    PH_WRITE_REG  = 2'd0,
    PH_WRITE_DATA = 2'd1,
    PH_READ_REG   = 2'd2,
    PH_READ_DATA  = 2'd3
  } phase_t;

  // Byte counts programmed with a start
  localparam logic [7:0] WRITE_XFER_LEN   = 8'd2;
  localparam logic [7:0] REG_PTR_XFER_LEN = 8'd1;

  // Sequencer state held between items
  typedef struct packed {
    xfer_state_t xstate;
    phase_t      phase;
    logic [6:0]  held_device;
    logic [7:0]  held_register;
    logic [7:0]  held_data;
    logic [7:0]  held_length;
    logic [7:0]  rx_count;
  } seq_regs_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic        issue_start;
    logic [6:0]  target_address;
    logic        read_direction;
    logic [7:0]  byte_count;
    logic        auto_end;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_position;
    logic [7:0]  rx_value;
    xfer_state_t transfer_state;
  } result_t;

  // Bus event flags of one event item
  typedef struct packed {
    logic tx_ready;
    logic transfer_done;
    logic rx_ready;
    logic stop;
    logic nack;
    logic bus_error;
  } bus_flags_t;

endpackage

// File: design/i2crts_step.sv
// Per-item update of the sequencer: next state and result for one command or bus event.
// Depends on i2crts_pkg.
module i2crts_step (
  input  logic [1:0]             func,
  input  logic [6:0]             dev_address,
  input  logic [7:0]             reg_address,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             read_length,
  input  i2crts_pkg::bus_flags_t flags,
  input  logic [7:0]             rx_byte,
  input  i2crts_pkg::seq_regs_t  regs,
  output i2crts_pkg::seq_regs_t  regs_next,
  output i2crts_pkg::result_t    res
);
  import i2crts_pkg::*;

  logic   busy;
  phase_t ph;

  assign busy = (regs.xstate == XS_BUSY);

  always_comb begin
    regs_next = regs;
    res       = '0;
    ph        = regs.phase;
    unique case (func_t'(func))
      // Register write: one two-byte transfer with stop
      FUNC_WRITE: begin
        if (busy) begin
          res.status = STS_BUSY;
        end else begin
          regs_next.xstate        = XS_BUSY;
          regs_next.held_device   = dev_address;
          regs_next.held_register = reg_address;
          regs_next.held_data     = data_byte;
          regs_next.phase         = PH_WRITE_REG;
          res.status              = STS_STARTED;
          res.issue_start         = 1'b1;
          res.target_address      = dev_address;
          res.byte_count          = WRITE_XFER_LEN;
          res.auto_end            = 1'b1;
        end
      end
      // Register read: pointer write first, no stop
      FUNC_READ: begin
        if (read_length == '0) begin
          res.status = STS_ZERO_LEN;
        end else if (busy) begin
          res.status = STS_BUSY;
        end else begin
          regs_next.xstate        = XS_BUSY;
          regs_next.held_device   = dev_address;
          regs_next.held_register = reg_address;
          regs_next.held_length   = read_length;
          regs_next.rx_count      = '0;
          regs_next.phase         = PH_READ_REG;
          res.status              = STS_STARTED;
          res.issue_start         = 1'b1;
          res.target_address      = dev_address;
          res.byte_count          = REG_PTR_XFER_LEN;
        end
      end
      // Bus event, ignored when not busy
      FUNC_EVENT: begin
        if (busy) begin
          // TX ready: feed register or data byte
          if (flags.tx_ready) begin
            case (ph)
              PH_WRITE_REG: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = regs.held_register;
                ph           = PH_WRITE_DATA;
              end
              PH_WRITE_DATA: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = regs.held_data;
              end
              PH_READ_REG: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = regs.held_register;
              end
              default: ;
            endcase
          end
          // Pointer write done: repeated start for the read
          if (flags.transfer_done && ph == PH_READ_REG) begin
            ph                 = PH_READ_DATA;
            res.issue_start    = 1'b1;
            res.target_address = regs.held_device;
            res.read_direction = 1'b1;
            res.byte_count     = regs.held_length;
            res.auto_end       = 1'b1;
          end
          // Received byte, dropped past the requested length
          if (flags.rx_ready && ph == PH_READ_DATA && regs.rx_count < regs.held_length) begin
            res.rx_valid       = 1'b1;
            res.rx_position    = regs.rx_count;
            res.rx_value       = rx_byte;
            regs_next.rx_count = regs.rx_count + 8'd1;
          end
          regs_next.phase = ph;
          // Ending conditions: stop over nack over bus error
          if (flags.stop || flags.nack || flags.bus_error) begin
            regs_next.rx_count    = '0;
            regs_next.held_length = '0;
            if (flags.stop) begin
              regs_next.xstate = XS_SUCCESS;
              res.status       = STS_SUCCESS;
            end else if (flags.nack) begin
              regs_next.xstate = XS_NACK;
              res.status       = STS_NACK;
            end else begin
              regs_next.xstate = XS_BUS_ERR;
              res.status       = STS_BUS_ERR;
            end
          end
        end
      end
      FUNC_NONE: ;
      default: ;
    endcase
    res.transfer_state = regs_next.xstate;
  end

endmodule

// File: design/i2c_register_transfer_sequencer_core.sv
// I2C register transfer sequencer, top level. Depends on i2crts_pkg and i2crts_step.
// The result of an accepted input transfer is registered in the output register.
// Throughput: one item per cycle while out_ready is high; the output register is the only
// stage and takes a new item in the same cycle its result is taken.
// Reset (rst, synchronous): idle state, write-register phase, held fields and
// receive count cleared, output register empty.
module i2c_register_transfer_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [6:0] dev_address,
  input  logic [7:0] reg_address,
  input  logic [7:0] data_byte,
  input  logic [7:0] read_length,
  input  logic       flag_tx_ready,
  input  logic       flag_transfer_done,
  input  logic       flag_rx_ready,
  input  logic       flag_stop,
  input  logic       flag_nack,
  input  logic       flag_bus_error,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic       issue_start,
  output logic [6:0] target_address,
  output logic       read_direction,
  output logic [7:0] byte_count,
  output logic       auto_end,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_valid,
  output logic [7:0] rx_position,
  output logic [7:0] rx_value,
  output logic [2:0] transfer_state
);
  import i2crts_pkg::*;

  seq_regs_t  regs;
  seq_regs_t  regs_next;
  result_t    res;
  result_t    res_next;
  bus_flags_t flags;
  logic       accept;

  assign flags = '{tx_ready:      flag_tx_ready,
                   transfer_done: flag_transfer_done,
                   rx_ready:      flag_rx_ready,
                   stop:          flag_stop,
                   nack:          flag_nack,
                   bus_error:     flag_bus_error};

  // Take a new item whenever the output register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2crts_step u_step (
    .func        (func),
    .dev_address (dev_address),
    .reg_address (reg_address),
    .data_byte   (data_byte),
    .read_length (read_length),
    .flags       (flags),
    .rx_byte     (rx_byte),
    .regs        (regs),
    .regs_next   (regs_next),
    .res         (res_next)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.xstate        <= XS_IDLE;
      regs.phase         <= PH_WRITE_REG;
      regs.held_device   <= '0;
      regs.held_register <= '0;
      regs.held_data     <= '0;
      regs.held_length   <= '0;
      regs.rx_count      <= '0;
    end else if (accept) begin
      regs <= regs_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign status         = res.status;
  assign issue_start    = res.issue_start;
  assign target_address = res.target_address;
  assign read_direction = res.read_direction;
  assign byte_count     = res.byte_count;
  assign auto_end       = res.auto_end;
  assign tx_valid       = res.tx_valid;
  assign tx_byte        = res.tx_byte;
  assign rx_valid       = res.rx_valid;
  assign rx_position    = res.rx_position;
  assign rx_value       = res.rx_value;
  assign transfer_state = res.transfer_state;

  // A write start taken while not busy leaves the block busy and reports started
  a_write_start: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_WRITE && regs.xstate != XS_BUSY)
      |=> (regs.xstate == XS_BUSY && out_valid && res.status == STS_STARTED))
    else $error("write start did not enter busy");

  // Receive count never passes the requested length
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    regs.rx_count <= regs.held_length)
    else $error("rx_count beyond held_length");

  // A pending result reports the state the block is in
  a_state_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.transfer_state == regs.xstate))
    else $error("transfer_state out of step with sequencer state");

  // A stored byte advances the receive count by one unless the transfer ends with it
  a_rx_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.rx_valid && !(flag_stop || flag_nack || flag_bus_error))
      |=> (regs.rx_count == $past(regs.rx_count) + 8'd1))
    else $error("rx_count did not advance with stored byte");

endmodule
